// ===== src/gcra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcra_pkg
// Shared types and constants of the GCRA rate limiter.
// ----------------------------------------------------------------------------
package gcra_pkg;

  localparam int TIME_BITS_DEF = 64;

  localparam int QUO_W      = 36;
  localparam int RATE_W     = 32;
  localparam int NS_SEC_W   = 30;
  localparam int RETRY_NS_W = RATE_W + NS_SEC_W;

  localparam logic [QUO_W-1:0]    NS_PER_MINUTE = QUO_W'(64'd60_000_000_000);
  localparam logic [NS_SEC_W-1:0] NS_PER_SECOND = NS_SEC_W'(64'd1_000_000_000);

  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t REG_RPM   = 1'b0;
  localparam cfg_idx_t REG_BURST = 1'b1;

  typedef enum logic [1:0] {
    MODE_TRY     = 2'd0,
    MODE_RESERVE = 2'd1,
    MODE_NOTIFY  = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

endpackage

// ===== src/gcra_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcra_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface gcra_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] now_ns;
  logic [31:0] retry_after_s;

  modport source (output valid, mode, now_ns, retry_after_s, input ready);
  modport sink   (input valid, mode, now_ns, retry_after_s, output ready);
endinterface

interface gcra_out_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [63:0] wait_ns;

  modport source (output valid, granted, wait_ns, input ready);
  modport sink   (input valid, granted, wait_ns, output ready);
endinterface

// ===== src/gcra_cfg_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcra_cfg_calc
// Holds the rate registers and derives emission interval and burst window
// with a bit-serial divider followed by a shift-add multiplier.
// ----------------------------------------------------------------------------
module gcra_cfg_calc #(
  parameter int TIME_BITS = gcra_pkg::TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  gcra_pkg::cfg_idx_t      cfg_idx,
  input  logic [31:0]             cfg_wdata,
  output logic                    busy,
  output logic [TIME_BITS-1:0]    interval,
  output logic [TIME_BITS-1:0]    window
);
  import gcra_pkg::*;

  localparam int ACC_W     = QUO_W + RATE_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int MUL_STEPS = RATE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [ACC_W-1:0] TMAX_ACC = (ACC_W'(1) << TIME_BITS) - ACC_W'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_MUL  = 3'b100
  } calc_state_t;

  calc_state_t        state;
  logic [RATE_W-1:0]  rpm;
  logic [RATE_W-1:0]  burst;
  logic [QUO_W-1:0]   dvd;
  logic [RATE_W-1:0]  rem;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   mcand;
  logic [RATE_W-1:0]  mplier;
  logic [CNT_W-1:0]   cnt;

  logic [RATE_W:0]    rem_sh;
  logic               ge;
  logic [RATE_W:0]    rem_sub;
  logic [QUO_W-1:0]   dvd_next;
  logic [ACC_W-1:0]   acc_next;
  logic [RATE_W-1:0]  eff;

  assign rem_sh   = {rem, dvd[QUO_W-1]};
  assign ge       = rem_sh >= {1'b0, rpm};
  assign rem_sub  = rem_sh - {1'b0, rpm};
  assign dvd_next = {dvd[QUO_W-2:0], ge};
  assign acc_next = mplier[0] ? acc + mcand : acc;
  assign eff      = (burst != '0) ? burst : rpm;
  assign busy     = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rpm      <= '0;
      burst    <= '0;
      interval <= '0;
      window   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RPM:   rpm   <= cfg_wdata;
        REG_BURST: burst <= cfg_wdata;
      endcase
      state <= S_DIV;
    end else begin
      unique case (state)
        S_IDLE: ;
        S_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            interval <= (rpm == '0) ? '0 : TIME_BITS'(dvd_next);
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            window <= (acc_next > TMAX_ACC) ? '1 : acc_next[TIME_BITS-1:0];
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath of the serial units
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      dvd <= NS_PER_MINUTE;
      rem <= '0;
      cnt <= '0;
    end else if (state == S_DIV) begin
      dvd <= dvd_next;
      rem <= ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        cnt    <= '0;
        acc    <= '0;
        mcand  <= (rpm == '0) ? '0 : ACC_W'(dvd_next);
        mplier <= eff;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (state == S_MUL) begin
      acc    <= acc_next;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      cnt    <= cnt + 1'b1;
    end
  end

endmodule

// ===== src/gcra_rate_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcra_rate_limiter
// GCRA limiter: try, reserve, notify and query against a theoretical arrival
// time and a server block barrier.
// ----------------------------------------------------------------------------
// A request passes the input register, then the result register, whose valid
// drives the response.
// Throughput: one request per cycle unless the response stalls or a rate is
// being recomputed. A config write keeps ready low through the 36-step divide
// and 32-step multiply and clears the arrival time at once.
// Reset clears valids, rates and timing state; rate 0 means limiting is off.
// ----------------------------------------------------------------------------
module gcra_rate_limiter #(
  parameter int TIME_BITS = gcra_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  gcra_in_if.sink            req,
  gcra_out_if.source         rsp,
  input  logic               cfg_we,
  input  gcra_pkg::cfg_idx_t cfg_idx,
  input  logic [31:0]        cfg_wdata
);
  import gcra_pkg::*;

  localparam logic [63:0] TMAX64 = {64{1'b1}} >> (64 - TIME_BITS);

  typedef logic [TIME_BITS-1:0] tm_t;

  function automatic tm_t sat_add(tm_t a, tm_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  function automatic tm_t max_t(tm_t a, tm_t b);
    return (a > b) ? a : b;
  endfunction

  logic busy;
  tm_t  interval;
  tm_t  window;

  gcra_cfg_calc #(.TIME_BITS(TIME_BITS)) u_calc (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .busy     (busy),
    .interval (interval),
    .window   (window)
  );

  tm_t arrival_time;
  tm_t block_barrier;

  // input register
  logic                  s1_valid;
  mode_t                 s1_mode;
  tm_t                   s1_now;
  logic [RETRY_NS_W-1:0] s1_retry_ns;
  logic                  s1_adv;

  // result register
  logic                  out_valid;
  logic                  out_granted;
  logic [63:0]           out_wait;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !busy && (!s1_valid || s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_mode     <= mode_t'(req.mode);
      s1_now      <= req.now_ns[TIME_BITS-1:0];
      s1_retry_ns <= RETRY_NS_W'(req.retry_after_s) * RETRY_NS_W'(NS_PER_SECOND);
    end
  end

  // decision logic
  tm_t   at;
  logic  blocked;
  tm_t   new_tat;
  tm_t   due;
  tm_t   slot_wait;
  tm_t   limit;
  tm_t   retry_sat;
  tm_t   bar_end;
  logic  limiting;

  logic  granted_next;
  tm_t   wait_next;
  logic  tat_we;
  logic  bar_we;

  always_comb begin
    limiting  = (interval != '0);
    blocked   = s1_now < block_barrier;
    at        = max_t(s1_now, block_barrier);
    new_tat   = sat_add(max_t(arrival_time, at), interval);
    due       = (new_tat > window) ? new_tat - window : '0;
    slot_wait = max_t(due, at) - s1_now;
    limit     = sat_add(s1_now, window);
    retry_sat = (64'(s1_retry_ns) > TMAX64) ? '1 : TIME_BITS'(s1_retry_ns);
    bar_end   = sat_add(s1_now, retry_sat);

    granted_next = 1'b0;
    wait_next    = '0;
    tat_we       = 1'b0;
    bar_we       = 1'b0;
    case (s1_mode)
      MODE_TRY: begin
        if (!limiting) begin
          granted_next = 1'b1;
        end else if (!blocked && new_tat <= limit) begin
          granted_next = 1'b1;
          tat_we       = 1'b1;
        end
      end
      MODE_RESERVE: begin
        granted_next = 1'b1;
        if (limiting) begin
          tat_we    = 1'b1;
          wait_next = slot_wait;
        end
      end
      MODE_NOTIFY: begin
        bar_we = bar_end > block_barrier;
      end
      MODE_QUERY: begin
        if (limiting) begin
          wait_next = blocked ? block_barrier - s1_now : slot_wait;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_time  <= '0;
      block_barrier <= '0;
    end else begin
      if (cfg_we) begin
        arrival_time <= '0;
      end else if (s1_adv && tat_we) begin
        arrival_time <= new_tat;
      end
      if (s1_adv && bar_we) begin
        block_barrier <= bar_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_granted <= granted_next;
      out_wait    <= 64'(wait_next);
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.granted = out_granted;
  assign rsp.wait_ns = out_wait;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.ready)
    else $error("request accepted while rate is being recomputed");

  a_cfg_clears_tat: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> arrival_time == '0)
    else $error("arrival time not cleared by config write");

  a_barrier_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> block_barrier >= $past(block_barrier))
    else $error("block barrier moved earlier");

  a_no_grant_notify: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_mode == MODE_NOTIFY |=> !out_granted && out_wait == '0)
    else $error("notify produced a grant or a wait");

endmodule
